// ===== hdl/tmc_pkg.sv =====
// Shared types and constants for the thermostat mode controller.
package tmc_pkg;

  // An invalid reading that lasts longer than this many milliseconds latches the error.
  localparam logic [31:0] INVALID_TIMEOUT_MS = 32'd30000;

  // Fan speed limit in percent.
  localparam logic [6:0] FAN_MAX = 7'd100;

  // Scale for dividing by 100: x / 100 == (x * 5243) >> 19 for all x below 43690.
  localparam logic [12:0] PWM_RECIP = 13'd5243;
  localparam int unsigned PWM_SHIFT = 19;

  // Operating modes. The codes six and seven have no meaning and keep the drive.
  typedef enum logic [2:0] {
    CTRL_OFF    = 3'd0,
    CTRL_AUTO   = 3'd1,
    CTRL_MANUAL = 3'd2,
    CTRL_HEAT   = 3'd3,
    CTRL_COOL   = 3'd4,
    CTRL_FAN    = 3'd5
  } mode_e;

  // Status codes as shown in the result word.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_HEAT  = 3'd1,
    ST_COOL  = 3'd2,
    ST_FAN   = 3'd3,
    ST_ERROR = 3'd4
  } status_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_TARGET     = 3'd1,
    REG_FAN_SPEED  = 3'd2,
    REG_DEADBAND   = 3'd3,
    REG_MIN_TEMP   = 3'd4,
    REG_MAX_TEMP   = 3'd5,
    REG_INTERVAL   = 3'd6,
    REG_BUZZER     = 3'd7
  } reg_e;

  // One sensor sample.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [11:0] temperature;
    logic               sensor_valid;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic       updated;
    logic       heat_on;
    logic       cool_on;
    logic [6:0] fan_percent;
    logic [7:0] fan_pwm;
    logic [2:0] status;
    logic       alarm;
  } out_word_t;

endpackage

// ===== hdl/thermostat_mode_controller.sv =====
// Deadband thermostat with mode select, sample interval gating and a safety latch.
//
//   channel   direction  handshake                 word
//   -------   ---------  ------------------------  ----------
//   in        sink       in_valid_i / in_stall_o   in_word_t
//   out       source     out_valid_o / out_stall_i out_word_t
//   config    APB        psel/penable/pwrite       32-bit data
//
// A word is held in the input register and then moves into the output register,
// and one word is taken every cycle while the result side is not stalled.
// All decisions for a word are made in the single stage between the two registers.
// Reset clears the control state and loads the register defaults; no clearing pass.
// A stalled output holds its word while the input register keeps the next one.
module thermostat_mode_controller
  import tmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [2:0]         mode_q;
  logic signed [11:0] target_q;
  logic [6:0]         fan_speed_q;
  logic [7:0]         deadband_q;
  logic signed [11:0] min_temp_q;
  logic signed [11:0] max_temp_q;
  logic [15:0]        interval_q;
  logic               buzzer_q;

  // Controller state.
  logic [31:0] last_used_q, last_used_d;
  logic [31:0] inv_since_q, inv_since_d;
  logic        inv_timing_q, inv_timing_d;
  logic        heat_q, heat_d;
  logic        cool_q, cool_d;
  logic [6:0]  fan_q, fan_d;
  status_e     status_q, status_d;

  // Pipeline registers.
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic       advance;
  logic       cfg_wr;
  reg_e       cfg_idx;
  logic [6:0] fan_wr;

  // Fan duty from percent: pct * 255 / 100, truncated.
  function automatic logic [7:0] pwm_of(logic [6:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = {pct, 8'b0} - {8'b0, pct};
    prod   = 28'(scaled) * 28'(PWM_RECIP);
    return prod[PWM_SHIFT+7:PWM_SHIFT];
  endfunction

  // Configuration write and read decode; byte lanes within a register are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);
  assign fan_wr  = (pwdata[6:0] > FAN_MAX) ? FAN_MAX : pwdata[6:0];

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:      prdata = 32'(mode_q);
      REG_TARGET:    prdata = 32'(target_q);
      REG_FAN_SPEED: prdata = 32'(fan_speed_q);
      REG_DEADBAND:  prdata = 32'(deadband_q);
      REG_MIN_TEMP:  prdata = 32'(min_temp_q);
      REG_MAX_TEMP:  prdata = 32'(max_temp_q);
      REG_INTERVAL:  prdata = 32'(interval_q);
      REG_BUZZER:    prdata = 32'(buzzer_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= CTRL_OFF;
      target_q    <= 12'sd352;
      fan_speed_q <= '0;
      deadband_q  <= 8'd16;
      min_temp_q  <= -12'sd640;
      max_temp_q  <= 12'sd1280;
      interval_q  <= 16'd1000;
      buzzer_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:      mode_q      <= pwdata[2:0];
        REG_TARGET:    target_q    <= pwdata[11:0];
        REG_FAN_SPEED: fan_speed_q <= fan_wr;
        REG_DEADBAND:  deadband_q  <= pwdata[7:0];
        REG_MIN_TEMP:  min_temp_q  <= pwdata[11:0];
        REG_MAX_TEMP:  max_temp_q  <= pwdata[11:0];
        REG_INTERVAL:  interval_q  <= pwdata[15:0];
        REG_BUZZER:    buzzer_q    <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // Handshake: the stage moves when the output register is free or being drained.
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Decision logic for the word in the input register.
  logic               used;
  logic               new_err;
  logic               err_now;
  logic signed [11:0] temp;
  logic signed [11:0] tgt;
  logic signed [12:0] diff;
  logic signed [12:0] band;

  always_comb begin
    temp = in_word_q.temperature;
    used = (in_word_q.now_ms - last_used_q) >= 32'(interval_q);

    // Target clamp tests the low bound first, as the limits may be crossed.
    if (target_q < min_temp_q) begin
      tgt = min_temp_q;
    end else if (target_q > max_temp_q) begin
      tgt = max_temp_q;
    end else begin
      tgt = target_q;
    end
    diff = 13'(tgt) - 13'(temp);
    band = $signed({5'b0, deadband_q});

    last_used_d  = last_used_q;
    inv_since_d  = inv_since_q;
    inv_timing_d = inv_timing_q;
    heat_d       = heat_q;
    cool_d       = cool_q;
    fan_d        = fan_q;
    status_d     = status_q;
    new_err      = 1'b0;

    if (used) begin
      // Safety rules: invalid-data timeout and range check.
      if (!in_word_q.sensor_valid) begin
        if (!inv_timing_q) begin
          inv_timing_d = 1'b1;
          inv_since_d  = in_word_q.now_ms;
        end else if ((in_word_q.now_ms - inv_since_q) > INVALID_TIMEOUT_MS) begin
          new_err = 1'b1;
        end
      end else begin
        inv_timing_d = 1'b0;
        inv_since_d  = '0;
        new_err      = (temp < min_temp_q) | (temp > max_temp_q);
      end
      err_now = new_err | (status_q == ST_ERROR);

      if (err_now) begin
        heat_d   = 1'b0;
        cool_d   = 1'b0;
        fan_d    = '0;
        status_d = ST_ERROR;
      end else begin
        last_used_d = in_word_q.now_ms;
        unique case (mode_q)
          CTRL_OFF: begin
            heat_d   = 1'b0;
            cool_d   = 1'b0;
            fan_d    = '0;
            status_d = ST_IDLE;
          end
          CTRL_AUTO: begin
            // Deadband control; an invalid sample keeps the drive.
            if (in_word_q.sensor_valid) begin
              if (diff > band) begin
                heat_d   = 1'b1;
                cool_d   = 1'b0;
                fan_d    = fan_speed_q;
                status_d = ST_HEAT;
              end else if (diff < -band) begin
                heat_d   = 1'b0;
                cool_d   = 1'b1;
                fan_d    = fan_speed_q;
                status_d = ST_COOL;
              end else begin
                heat_d   = 1'b0;
                cool_d   = 1'b0;
                fan_d    = '0;
                status_d = ST_IDLE;
              end
            end
          end
          CTRL_HEAT: begin
            heat_d   = 1'b1;
            cool_d   = 1'b0;
            fan_d    = fan_speed_q;
            status_d = ST_HEAT;
          end
          CTRL_COOL: begin
            heat_d   = 1'b0;
            cool_d   = 1'b1;
            fan_d    = fan_speed_q;
            status_d = ST_COOL;
          end
          CTRL_FAN: begin
            heat_d   = 1'b0;
            cool_d   = 1'b0;
            fan_d    = fan_speed_q;
            status_d = ST_FAN;
          end
          default: ;  // Manual and unused codes keep the drive.
        endcase
      end
    end else begin
      err_now = 1'b0;
    end

    out_word_d.updated     = used;
    out_word_d.heat_on     = heat_d;
    out_word_d.cool_on     = cool_d;
    out_word_d.fan_percent = fan_d;
    out_word_d.fan_pwm     = pwm_of(fan_d);
    out_word_d.status      = status_d;
    out_word_d.alarm       = (status_d == ST_ERROR) & buzzer_q;

    // Output register is loaded on advance and emptied when taken.
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Controller state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_used_q  <= '0;
      inv_since_q  <= '0;
      inv_timing_q <= 1'b0;
      heat_q       <= 1'b0;
      cool_q       <= 1'b0;
      fan_q        <= '0;
      status_q     <= ST_IDLE;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        last_used_q  <= last_used_d;
        inv_since_q  <= inv_since_d;
        inv_timing_q <= inv_timing_d;
        heat_q       <= heat_d;
        cool_q       <= cool_d;
        fan_q        <= fan_d;
        status_q     <= status_d;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// ===== hdl/tmc_checker.sv =====
// Port-level assertions for the thermostat mode controller, bound to the top level.
module tmc_checker
  import tmc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_word_t   out_word_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // The input side stalls only behind a waiting, stalled result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result side is free");

  // Heater and cooler are never driven together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.heat_on && out_word_o.cool_on))
    else $error("heater and cooler both on");

  // Error and idle status both mean all outputs off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_ERROR || out_word_o.status == ST_IDLE)
    |-> !out_word_o.heat_on && !out_word_o.cool_on && out_word_o.fan_percent == '0)
    else $error("drive active in error or idle status");

  // The alarm is raised only in error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.alarm |-> out_word_o.status == ST_ERROR)
    else $error("alarm without error status");

endmodule

bind thermostat_mode_controller tmc_checker u_tmc_checker (.*);
